### src/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UTF8SD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/utf8sd_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package utf8sd_pkg;

	typedef enum logic [1:0] {
		KIND_CP      = 2'd0,
		KIND_BADLEAD = 2'd1,
		KIND_STRAY   = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	localparam logic CFG_HOLD_PARTIAL  = 1'b0;
	localparam logic CFG_NUL_ENDS_TEXT = 1'b1;

	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;
	localparam logic [7:0] CONT_MAX    = 8'hBF;
	localparam logic [7:0] LEAD_MIN    = 8'hC2;
	localparam logic [7:0] LEAD_MAX    = 8'hF4;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] LEAD_ED     = 8'hED;
	localparam logic [7:0] CONT_A0     = 8'hA0;
	localparam logic [7:0] CONT_90     = 8'h90;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [20:0] value;
		kind_t       kind;
		logic [1:0]  good_following;
		logic [1:0]  pending_bytes;
		logic        last;
	} out_item_t;

	// One queued job: optional flush (bad lead plus held continuations),
	// then an optional single tail result.
	typedef struct packed {
		logic        has_flush;
		logic [7:0]  lead;
		logic [1:0]  held_n;
		logic [7:0]  held0;
		logic [7:0]  held1;
		logic        has_tail;
		logic [20:0] tail_value;
		kind_t       tail_kind;
		logic [1:0]  tail_pend;
	} job_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} q_status_t;

endpackage

### src/utf8sd_front.sv
// Front end of the UTF-8 stream decoder: accepts bytes, tracks the open
// sequence and turns each item that causes results into a job. Depends on utf8sd_pkg.
module utf8sd_front import utf8sd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	input  logic      hold_partial,
	input  logic      nul_ends_text,
	input  q_status_t q_status,
	output logic      push,
	output job_t      push_job
);

	logic [7:0] lead_q;
	logic [7:0] held_q [2];
	logic [1:0] held_cnt_q;
	logic [1:0] seq_len_q;

	logic [7:0] lead_d;
	logic [1:0] held_cnt_d;
	logic [1:0] seq_len_d;
	logic       hold_wr;
	logic       accept;
	logic       job_any;
	logic [7:0] b;
	logic       eot;
	logic       nul_end;
	logic       cont_ok;
	logic       complete;
	logic [20:0] cp;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;
	assign b        = in_data.data_byte;
	assign eot      = in_data.end_of_text;
	assign nul_end  = !eot && (b == 8'h00) && nul_ends_text;

	always_comb begin
		cont_ok = ((b & CONT_MASK) == CONT_TAG);
		if (cont_ok && (held_cnt_q == 2'd0)) begin
			unique case (lead_q)
				LEAD3_MIN: cont_ok = (b >= CONT_A0);
				LEAD4_MIN: cont_ok = (b >= CONT_90);
				LEAD_ED:   cont_ok = (b < CONT_A0);
				LEAD_MAX:  cont_ok = (b < CONT_90);
				default:   cont_ok = 1'b1;
			endcase
		end
	end

	assign complete = ({1'b0, held_cnt_q} + 3'd1) >= {1'b0, seq_len_q};

	always_comb begin
		unique case (seq_len_q)
			2'd1:    cp = {10'd0, lead_q[4:0], b[5:0]};
			2'd2:    cp = {5'd0, lead_q[3:0], held_q[0][5:0], b[5:0]};
			default: cp = {lead_q[2:0], held_q[0][5:0], held_q[1][5:0], b[5:0]};
		endcase
	end

	always_comb begin
		push_job            = '0;
		push_job.lead       = lead_q;
		push_job.held_n     = held_cnt_q;
		push_job.held0      = held_q[0];
		push_job.held1      = held_q[1];
		push_job.tail_kind  = KIND_CP;
		lead_d              = lead_q;
		held_cnt_d          = held_cnt_q;
		seq_len_d           = seq_len_q;
		hold_wr             = 1'b0;
		if (eot || nul_end) begin
			push_job.has_tail  = 1'b1;
			push_job.tail_kind = KIND_END;
			if (seq_len_q != 2'd0 && eot && hold_partial) begin
				// keep the sequence open for the next chunk
				push_job.tail_pend = held_cnt_q + 2'd1;
			end else begin
				push_job.has_flush = (seq_len_q != 2'd0);
				seq_len_d  = 2'd0;
				held_cnt_d = 2'd0;
			end
		end else if (seq_len_q != 2'd0 && cont_ok) begin
			if (complete) begin
				push_job.has_tail   = 1'b1;
				push_job.tail_value = cp;
				seq_len_d  = 2'd0;
				held_cnt_d = 2'd0;
			end else begin
				hold_wr    = 1'b1;
				held_cnt_d = held_cnt_q + 2'd1;
			end
		end else begin
			// a broken sequence is flushed first, then the byte starts afresh
			push_job.has_flush = (seq_len_q != 2'd0);
			seq_len_d  = 2'd0;
			held_cnt_d = 2'd0;
			push_job.tail_value = {13'd0, b};
			if (b < CONT_TAG) begin
				push_job.has_tail  = 1'b1;
				push_job.tail_kind = KIND_CP;
			end else if (b <= CONT_MAX) begin
				push_job.has_tail  = 1'b1;
				push_job.tail_kind = KIND_STRAY;
			end else if (b < LEAD_MIN || b > LEAD_MAX) begin
				push_job.has_tail  = 1'b1;
				push_job.tail_kind = KIND_BADLEAD;
			end else begin
				lead_d = b;
				seq_len_d = (b < LEAD3_MIN) ? 2'd1 : ((b < LEAD4_MIN) ? 2'd2 : 2'd3);
			end
		end
	end

	assign job_any = push_job.has_flush || push_job.has_tail;
	assign push    = accept && job_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= '0;
			held_cnt_q <= '0;
			seq_len_q  <= '0;
		end else if (accept) begin
			lead_q     <= lead_d;
			held_cnt_q <= held_cnt_d;
			seq_len_q  <= seq_len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_wr) begin
			held_q[held_cnt_q[0]] <= b;
		end
	end

endmodule

### src/utf8sd_queue.sv
// Two-entry job queue between front and back of the UTF-8 stream decoder.
// Depends on utf8sd_pkg.
module utf8sd_queue import utf8sd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output q_status_t q_status,
	output job_t      head_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_status.full       = (cnt_q == 2'd2);
	assign q_status.head_valid = (cnt_q != 2'd0);
	assign head_job            = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### src/utf8sd_back.sv
// Back end of the UTF-8 stream decoder: expands the head job into result transactions,
// one per cycle while out_stall allows, through an output register. Depends on utf8sd_pkg.
module utf8sd_back import utf8sd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_status,
	input  job_t      head_job,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic       out_valid_q;
	out_item_t  out_data_q;
	logic [1:0] idx_q;
	logic [2:0] nflush;
	logic [2:0] total;
	logic       emit;
	logic       is_last;
	out_item_t  res;

	assign nflush  = head_job.has_flush ? ({1'b0, head_job.held_n} + 3'd1) : 3'd0;
	assign total   = nflush + {2'b0, head_job.has_tail};
	assign is_last = ({1'b0, idx_q} + 3'd1) == total;
	assign emit    = q_status.head_valid && (!out_valid_q || !out_stall);
	assign pop     = emit && is_last;

	always_comb begin
		res      = '0;
		res.last = is_last;
		res.kind = KIND_CP;
		if ({1'b0, idx_q} < nflush) begin
			if (idx_q == 2'd0) begin
				res.value          = {13'd0, head_job.lead};
				res.kind           = KIND_BADLEAD;
				res.good_following = head_job.held_n;
			end else begin
				res.value = {13'd0, (idx_q == 2'd1) ? head_job.held0 : head_job.held1};
				res.kind  = KIND_STRAY;
			end
		end else begin
			res.value         = head_job.tail_value;
			res.kind          = head_job.tail_kind;
			res.pending_bytes = head_job.tail_pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### src/utf8_stream_decoder.sv
// Top level of the strict UTF-8 stream decoder.
// Depends on utf8sd_pkg, utf8sd_front, utf8sd_queue, utf8sd_back and the assert header.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | in_valid / in_stall       | in_data  (data_byte, end_of_text)
//  output   | out_valid / out_stall     | out_data (value, kind, good_following,
//           |                           |           pending_bytes, last)
//  config   | cfg_we                    | cfg_index, cfg_data
//
// The front takes one input transaction per cycle while the two-entry job
// queue has room. The back drains the queue at one result per cycle while
// out_stall is low, so an item with k results (0 to 4) holds the back until
// all k are sent; items with at most one result stream at one per cycle.
// An item's job is registered in the queue, and its results then in the
// output register. Reset clears the decode state, the queue and the output
// register; out_stall backs up into the queue and then in_stall.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder import utf8sd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic      cfg_data
);

	// Configuration registers; the user must write them only while the block is idle; the block leaves this to the user.
	logic hold_partial_q;
	logic nul_ends_text_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_partial_q  <= 1'b0;
			nul_ends_text_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HOLD_PARTIAL:  hold_partial_q  <= cfg_data;
				CFG_NUL_ENDS_TEXT: nul_ends_text_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Front to queue: one job per input transaction that causes results.
	logic      push;
	job_t      push_job;
	q_status_t q_status;

	// Queue to back: head job and its release.
	job_t      head_job;
	logic      pop;

	utf8sd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.hold_partial  (hold_partial_q),
		.nul_ends_text (nul_ends_text_q),
		.q_status      (q_status),
		.push          (push),
		.push_job      (push_job)
	);

	utf8sd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_status (q_status),
		.head_job (head_job)
	);

	utf8sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// End of text always closes the results of its item.
	`UTF8SD_ASSERT_NOW(a_end_is_last, out_valid && (out_data.kind == KIND_END), out_data.last, "end-of-text result without last")

	// Only a bad lead carries a count of good continuations.
	`UTF8SD_ASSERT_NOW(a_good_only_badlead, out_valid && (out_data.kind != KIND_BADLEAD), out_data.good_following == 2'd0, "good_following set on non-bad-lead result")

	// The front only stalls when the queue holds work.
	`UTF8SD_ASSERT_NOW(a_stall_has_work, in_stall, q_status.head_valid, "input stalled with empty queue")

	// Popping a job always loads its final result into the output register.
	`UTF8SD_ASSERT_NEXT(a_pop_gives_last, pop, out_valid && out_data.last, "job released without last result")

endmodule

### dv/testbench.sv
// Self-checking testbench for the strict UTF-8 stream decoder.
// Depends on utf8sd_pkg and utf8_stream_decoder; drives a directed table, then random text.
`timescale 1ns / 100ps

module testbench;
	import utf8sd_pkg::*;

	// Cycles to let pass once no result is outstanding: a lead byte causes no
	// result, so the block may still hold an open sequence when the last result is seen.
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int PHASE_ITEMS     = 30;
	localparam int REPORT_LIMIT    = 10;
	// Register settings of the four random phases, bit p for phase p.
	localparam logic [3:0] PHASE_CHUNK = 4'b0101;
	localparam logic [3:0] PHASE_NUL   = 4'b1001;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_op_t;

	// One row of the directed table: an input transaction, optionally with its
	// single result typed in, or a register write.
	typedef struct packed {
		row_op_t   op;
		in_item_t  item;
		logic      typed;
		out_item_t want;
		logic      reg_idx;
		logic      reg_val;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_we;
	logic      cfg_index;
	logic      cfg_data;

	// Decoder state of the prediction, plus its copy of the registers.
	logic       hold_partial_q;
	logic       nul_end_q;
	logic [7:0] lead_q;
	logic [7:0] held_q [2];
	logic [1:0] held_n_q;
	logic [1:0] seq_len_q;

	out_item_t step_res [$];   // results caused by the item just decoded
	out_item_t decoded_q [$];  // decoded results still owed by the block
	stim_row_t plan_q [$];
	in_item_t  burst_q [$];

	// Shared between the stimulus and the receiver.
	bit no_idle;
	bit hold_req;

	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned kind_seen [4];
	int unsigned fail_count;

	always #1 clk = ~clk;

	utf8_stream_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic out_item_t make_result(logic [20:0] v, kind_t k, logic [1:0] g,
			logic [1:0] p);
		out_item_t r;
		r.value          = v;
		r.kind           = k;
		r.good_following = g;
		r.pending_bytes  = p;
		r.last           = 1'b0;
		return r;
	endfunction

	// Report the open sequence as a bad lead followed by its held continuations.
	task automatic flush_open();
		step_res.push_back(make_result({13'd0, lead_q}, KIND_BADLEAD, held_n_q, 2'd0));
		for (int i = 0; i < held_n_q; i++)
			step_res.push_back(make_result({13'd0, held_q[i]}, KIND_STRAY, 2'd0, 2'd0));
		seq_len_q = 2'd0;
		held_n_q  = 2'd0;
	endtask

	// Byte seen with no sequence open: ASCII, stray, bad lead, or a new lead.
	task automatic take_fresh(logic [7:0] b);
		if (b < CONT_TAG) begin
			step_res.push_back(make_result({13'd0, b}, KIND_CP, 2'd0, 2'd0));
		end else if (b <= CONT_MAX) begin
			step_res.push_back(make_result({13'd0, b}, KIND_STRAY, 2'd0, 2'd0));
		end else if (b < LEAD_MIN || b > LEAD_MAX) begin
			step_res.push_back(make_result({13'd0, b}, KIND_BADLEAD, 2'd0, 2'd0));
		end else begin
			lead_q    = b;
			held_n_q  = 2'd0;
			seq_len_q = (b < LEAD3_MIN) ? 2'd1 : ((b < LEAD4_MIN) ? 2'd2 : 2'd3);
		end
	endtask

	// The first continuation after E0, F0, ED and F4 has a narrowed range.
	function automatic logic cont_ok(logic [7:0] b);
		if ((b & CONT_MASK) != CONT_TAG)
			return 1'b0;
		if (held_n_q != 2'd0)
			return 1'b1;
		case (lead_q)
			LEAD3_MIN: return b >= CONT_A0;
			LEAD4_MIN: return b >= CONT_90;
			LEAD_ED:   return b < CONT_A0;
			LEAD_MAX:  return b < CONT_90;
			default:   return 1'b1;
		endcase
	endfunction

	task automatic decode_item(in_item_t it);
		logic [7:0]  b;
		logic        nul_end;
		logic [20:0] cp;
		b       = it.data_byte;
		nul_end = !it.end_of_text && b == 8'h00 && nul_end_q;
		step_res.delete();
		if (it.end_of_text || nul_end) begin
			// Chunk mode keeps an open sequence on a real end marker only;
			// a zero byte always breaks it.
			if (seq_len_q != 2'd0 && it.end_of_text && hold_partial_q) begin
				step_res.push_back(make_result(21'd0, KIND_END, 2'd0, held_n_q + 2'd1));
			end else begin
				if (seq_len_q != 2'd0)
					flush_open();
				step_res.push_back(make_result(21'd0, KIND_END, 2'd0, 2'd0));
			end
		end else if (seq_len_q == 2'd0) begin
			take_fresh(b);
		end else if (cont_ok(b)) begin
			if (held_n_q + 1 >= seq_len_q) begin
				case (seq_len_q)
					2'd1:    cp = {10'd0, lead_q[4:0], b[5:0]};
					2'd2:    cp = {5'd0, lead_q[3:0], held_q[0][5:0], b[5:0]};
					default: cp = {lead_q[2:0], held_q[0][5:0], held_q[1][5:0], b[5:0]};
				endcase
				seq_len_q = 2'd0;
				held_n_q  = 2'd0;
				step_res.push_back(make_result(cp, KIND_CP, 2'd0, 2'd0));
			end else begin
				held_q[held_n_q[0]] = b;
				held_n_q++;
			end
		end else begin
			// Breaking byte: flush, then handle it as if nothing were open.
			flush_open();
			take_fresh(b);
		end
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Mostly back-to-back, sometimes a short gap, rarely a long one; none while no_idle is set.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one transaction, hold it until accepted, then predict its results.
	task automatic send_item(in_item_t it, logic typed, out_item_t want);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		decode_item(it);
		if (typed)
			decoded_q.push_back(want);
		else
			foreach (step_res[i]) decoded_q.push_back(step_res[i]);
		items_sent++;
	endtask

	// Drop valid and wait until the block has nothing left in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HOLD_PARTIAL)
			hold_partial_q = val;
		else
			nul_end_q = val;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------

	task automatic row_byte(logic [7:0] b, logic eot);
		stim_row_t r;
		r                  = '0;
		r.op               = ROW_ITEM;
		r.item.data_byte   = b;
		r.item.end_of_text = eot;
		plan_q.push_back(r);
	endtask

	task automatic row_known(logic [7:0] b, logic eot, logic [20:0] v, kind_t k,
			logic [1:0] g, logic [1:0] p);
		stim_row_t r;
		r                  = '0;
		r.op               = ROW_ITEM;
		r.item.data_byte   = b;
		r.item.end_of_text = eot;
		r.typed            = 1'b1;
		r.want             = make_result(v, k, g, p);
		r.want.last        = 1'b1;
		plan_q.push_back(r);
	endtask

	task automatic row_cfg(logic idx, logic val);
		stim_row_t r;
		r         = '0;
		r.op      = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		plan_q.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Random text
	// ------------------------------------------------------------------

	task automatic push_byte(logic [7:0] b);
		in_item_t it;
		it.data_byte   = b;
		it.end_of_text = 1'b0;
		burst_q.push_back(it);
	endtask

	// End marker with a random byte, since the byte must be ignored.
	task automatic push_eot();
		in_item_t it;
		it.data_byte   = 8'($urandom_range(0, 255));
		it.end_of_text = 1'b1;
		burst_q.push_back(it);
	endtask

	// Pick a valid scalar value of random length and encode it; lead byte first.
	task automatic random_char(output logic [3:0][7:0] enc, output int n);
		logic [20:0] lo;
		logic [20:0] hi;
		logic [20:0] cp;
		n = $urandom_range(1, 4);
		case (n)
			1:       begin lo = 21'h0;     hi = 21'h7F;     end
			2:       begin lo = 21'h80;    hi = 21'h7FF;    end
			3:       begin lo = 21'h800;   hi = 21'hFFFF;   end
			default: begin lo = 21'h10000; hi = 21'h10FFFF; end
		endcase
		case ($urandom_range(0, 9))
			0:       cp = lo;
			1:       cp = hi;
			default: cp = 21'($urandom_range(lo, hi));
		endcase
		// Step out of the surrogate range.
		if (n == 3 && cp >= 21'hD800 && cp <= 21'hDFFF)
			cp = cp - 21'h800;
		enc = '0;
		case (n)
			1: enc[0] = cp[7:0];
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
	endtask

	// Mostly well-formed characters; the rest truncated sequences, end markers,
	// zero bytes, noise and boundary leads with a random continuation.
	task automatic fill_burst();
		logic [3:0][7:0] enc;
		int              n;
		int              cut;
		int unsigned     r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			random_char(enc, n);
			cut = n;
			if (r >= 52 && n > 1)
				cut = $urandom_range(1, n - 1);
			for (int i = 0; i < cut; i++)
				push_byte(enc[i]);
			if (cut < n) begin
				if ($urandom_range(0, 1))
					push_eot();
				// Resume the cut sequence, across the end marker in chunk mode.
				if ($urandom_range(0, 1))
					for (int i = cut; i < n; i++)
						push_byte(enc[i]);
			end
		end else if (r < 75) begin
			push_byte(8'($urandom_range(0, 255)));
		end else if (r < 83) begin
			push_eot();
		end else if (r < 88) begin
			push_byte(8'h00);
		end else begin
			case ($urandom_range(0, 4))
				0:       push_byte(LEAD3_MIN);
				1:       push_byte(LEAD_ED);
				2:       push_byte(LEAD4_MIN);
				3:       push_byte(LEAD_MAX);
				default: push_byte(8'($urandom_range(LEAD_MIN, LEAD_MAX)));
			endcase
			push_byte(8'($urandom_range(CONT_TAG, CONT_MAX)));
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	initial begin
		out_item_t none;
		int        count;
		none      = '0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = 1'b0;
		cfg_data  = 1'b0;
		no_idle   = 1'b0;
		hold_req  = 1'b0;

		// Reset values of the registers and the decoder.
		hold_partial_q = 1'b0;
		nul_end_q      = 1'b1;
		lead_q         = 8'h00;
		held_n_q       = 2'd0;
		seq_len_q      = 2'd0;

		// Byte extremes and error codes straight after reset.
		row_known(8'h7F, 1'b0, 21'h7F, KIND_CP, 2'd0, 2'd0);
		row_known(8'h80, 1'b0, 21'h80, KIND_STRAY, 2'd0, 2'd0);
		row_known(8'hC0, 1'b0, 21'hC0, KIND_BADLEAD, 2'd0, 2'd0);
		row_known(8'hFF, 1'b0, 21'hFF, KIND_BADLEAD, 2'd0, 2'd0);
		// Overlong after E0, surrogate after ED, above range after F4.
		row_byte(8'hE0, 1'b0);
		row_byte(8'h9F, 1'b0);
		row_byte(8'hED, 1'b0);
		row_byte(8'hA0, 1'b0);
		row_byte(8'hF4, 1'b0);
		row_byte(8'h90, 1'b0);
		// Highest scalar value.
		row_byte(8'hF4, 1'b0);
		row_byte(8'h8F, 1'b0);
		row_byte(8'hBF, 1'b0);
		row_byte(8'hBF, 1'b0);
		// Break with two held continuations; the breaking byte opens a new lead,
		// flushed by the end marker outside chunk mode.
		row_byte(8'hF1, 1'b0);
		row_byte(8'h80, 1'b0);
		row_byte(8'h80, 1'b0);
		row_byte(8'hC3, 1'b0);
		row_byte(8'h00, 1'b1);
		row_known(8'h5A, 1'b1, 21'h0, KIND_END, 2'd0, 2'd0);
		// Zero byte as end inside a sequence.
		row_byte(8'hE1, 1'b0);
		row_byte(8'h00, 1'b0);
		// Chunk mode: leave the sequence pending, then finish it afterward.
		row_cfg(CFG_HOLD_PARTIAL, 1'b1);
		row_cfg(CFG_NUL_ENDS_TEXT, 1'b0);
		row_byte(8'hE0, 1'b0);
		row_byte(8'hA0, 1'b0);
		row_known(8'hC5, 1'b1, 21'h0, KIND_END, 2'd0, 2'd2);
		row_byte(8'h80, 1'b0);
		row_known(8'h00, 1'b0, 21'h0, KIND_CP, 2'd0, 2'd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].op == ROW_CFG) begin
				settle();
				write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
			end else begin
				send_item(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
			end
		end

		// Random phases, one register setting each; phase 1 carries the long
		// output hold-off, phase 2 runs without any idling.
		for (int p = 0; p < 4; p++) begin
			settle();
			write_reg(CFG_HOLD_PARTIAL, PHASE_CHUNK[p]);
			write_reg(CFG_NUL_ENDS_TEXT, PHASE_NUL[p]);
			no_idle = (p == 2);
			if (p == 1)
				hold_req = 1'b1;
			count = 0;
			while (count < PHASE_ITEMS) begin
				fill_burst();
				while (burst_q.size() != 0) begin
					send_item(burst_q.pop_front(), 1'b0, none);
					count++;
				end
			end
		end
		no_idle = 1'b0;

		// Drain, then give any stray late result time to show up.
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (decoded_q.size() != 0)
			fail_count += decoded_q.size();

		$display("Covered %0d input transactions and %0d results under all four register settings",
			items_sent, results_seen);
		$display("  code points %0d, bad leads %0d, strays %0d, end markers %0d",
			kind_seen[KIND_CP], kind_seen[KIND_BADLEAD], kind_seen[KIND_STRAY],
			kind_seen[KIND_END]);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stall runs, one long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		int unsigned n;
		int unsigned run;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// Hold off long enough for the queue to fill and stall the input.
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (no_idle) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				n = pick_gap();
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
				run = $urandom_range(1, 12);
				repeat (run) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare every accepted result with the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			kind_seen[out_data.kind]++;
			if (decoded_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result: value=%h kind=%0d good=%0d pend=%0d last=%0d",
						out_data.value, out_data.kind, out_data.good_following,
						out_data.pending_bytes, out_data.last);
			end else begin
				if (out_data.value !== decoded_q[0].value ||
						out_data.kind !== decoded_q[0].kind ||
						out_data.good_following !== decoded_q[0].good_following ||
						out_data.pending_bytes !== decoded_q[0].pending_bytes ||
						out_data.last !== decoded_q[0].last) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("mismatch: expected value=%h kind=%0d good=%0d pend=%0d last=%0d",
							decoded_q[0].value, decoded_q[0].kind,
							decoded_q[0].good_following, decoded_q[0].pending_bytes,
							decoded_q[0].last);
						$display("          actual   value=%h kind=%0d good=%0d pend=%0d last=%0d",
							out_data.value, out_data.kind, out_data.good_following,
							out_data.pending_bytes, out_data.last);
					end
				end
				void'(decoded_q.pop_front());
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("timeout with %0d results outstanding", decoded_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
